// ===== sv/pwsrc_pkg.sv =====
// Shared constants for the pulse waveform source: widths, register indexes, segment codes.
package pwsrc_pkg;

    localparam int TIME_WIDTH_DEF  = 32;
    localparam int LEVEL_WIDTH_DEF = 16;
    localparam int CFG_INDEX_WIDTH = 4;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFF_LEVEL   = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ON_LEVEL    = 4'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_DELAY = 4'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RISE_TIME   = 4'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FALL_TIME   = 4'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ON_TIME     = 4'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PERIOD_TIME = 4'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CYCLE_LIMIT = 4'd7;

    localparam logic [1:0] SEG_OFF  = 2'd0;
    localparam logic [1:0] SEG_ON   = 2'd1;
    localparam logic [1:0] SEG_RISE = 2'd2;
    localparam logic [1:0] SEG_FALL = 2'd3;

    function automatic int pipe_latency(input int tw, input int lw);
        return tw + lw + 7;
    endfunction

endpackage

// ===== sv/pwsrc_cfg_regs.sv =====
// Configuration register file with derived period and level step.
module pwsrc_cfg_regs #(
    parameter int TIME_WIDTH  = pwsrc_pkg::TIME_WIDTH_DEF,
    parameter int LEVEL_WIDTH = pwsrc_pkg::LEVEL_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [pwsrc_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [((TIME_WIDTH > LEVEL_WIDTH) ? TIME_WIDTH : LEVEL_WIDTH)-1:0] wr_data,
    output logic [LEVEL_WIDTH-1:0]                off_level,
    output logic [LEVEL_WIDTH-1:0]                on_level,
    output logic [TIME_WIDTH-1:0]                 start_delay,
    output logic [TIME_WIDTH-1:0]                 rise_time,
    output logic [TIME_WIDTH-1:0]                 fall_time,
    output logic [TIME_WIDTH-1:0]                 on_time,
    output logic [TIME_WIDTH-1:0]                 cycle_limit,
    output logic                                  period_nz,
    output logic [TIME_WIDTH+1:0]                 period_eff,
    output logic [LEVEL_WIDTH-1:0]                diff_mag,
    output logic                                  diff_neg
);

    logic [LEVEL_WIDTH-1:0] off_level_reg;
    logic [LEVEL_WIDTH-1:0] on_level_reg;
    logic [TIME_WIDTH-1:0]  start_delay_reg;
    logic [TIME_WIDTH-1:0]  rise_time_reg;
    logic [TIME_WIDTH-1:0]  fall_time_reg;
    logic [TIME_WIDTH-1:0]  on_time_reg;
    logic [TIME_WIDTH-1:0]  period_time_reg;
    logic [TIME_WIDTH-1:0]  cycle_limit_reg;
    logic [TIME_WIDTH+1:0]  period_eff_reg;
    logic [LEVEL_WIDTH-1:0] diff_mag_reg;
    logic                   diff_neg_reg;
    logic [TIME_WIDTH+1:0]  span_next;
    logic [TIME_WIDTH+1:0]  period_next;
    logic [LEVEL_WIDTH:0]   diff_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_level_reg   <= '0;
            on_level_reg    <= '0;
            start_delay_reg <= '0;
            rise_time_reg   <= '0;
            fall_time_reg   <= '0;
            on_time_reg     <= '0;
            period_time_reg <= '0;
            cycle_limit_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                pwsrc_pkg::REG_OFF_LEVEL:   off_level_reg   <= wr_data[LEVEL_WIDTH-1:0];
                pwsrc_pkg::REG_ON_LEVEL:    on_level_reg    <= wr_data[LEVEL_WIDTH-1:0];
                pwsrc_pkg::REG_START_DELAY: start_delay_reg <= wr_data[TIME_WIDTH-1:0];
                pwsrc_pkg::REG_RISE_TIME:   rise_time_reg   <= wr_data[TIME_WIDTH-1:0];
                pwsrc_pkg::REG_FALL_TIME:   fall_time_reg   <= wr_data[TIME_WIDTH-1:0];
                pwsrc_pkg::REG_ON_TIME:     on_time_reg     <= wr_data[TIME_WIDTH-1:0];
                pwsrc_pkg::REG_PERIOD_TIME: period_time_reg <= wr_data[TIME_WIDTH-1:0];
                pwsrc_pkg::REG_CYCLE_LIMIT: cycle_limit_reg <= wr_data[TIME_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        span_next = (TIME_WIDTH+2)'(rise_time_reg) + (TIME_WIDTH+2)'(on_time_reg)
                  + (TIME_WIDTH+2)'(fall_time_reg);
        if (span_next < (TIME_WIDTH+2)'(period_time_reg))
            period_next = (TIME_WIDTH+2)'(period_time_reg);
        else
            period_next = span_next;
        diff_next = {on_level_reg[LEVEL_WIDTH-1], on_level_reg}
                  - {off_level_reg[LEVEL_WIDTH-1], off_level_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_eff_reg <= '0;
            diff_mag_reg   <= '0;
            diff_neg_reg   <= 1'b0;
        end
        else
        begin
            period_eff_reg <= period_next;
            diff_neg_reg   <= diff_next[LEVEL_WIDTH];
            if (diff_next[LEVEL_WIDTH])
                diff_mag_reg <= LEVEL_WIDTH'((LEVEL_WIDTH+1)'(0) - diff_next);
            else
                diff_mag_reg <= diff_next[LEVEL_WIDTH-1:0];
        end
    end

    assign off_level   = off_level_reg;
    assign on_level    = on_level_reg;
    assign start_delay = start_delay_reg;
    assign rise_time   = rise_time_reg;
    assign fall_time   = fall_time_reg;
    assign on_time     = on_time_reg;
    assign cycle_limit = cycle_limit_reg;
    assign period_nz   = |{rise_time_reg, on_time_reg, fall_time_reg, period_time_reg};
    assign period_eff  = period_eff_reg;
    assign diff_mag    = diff_mag_reg;
    assign diff_neg    = diff_neg_reg;

endmodule

// ===== sv/pwsrc_phase.sv =====
// Phase pipeline: elapsed time, bit-per-stage division by the period, cycle limit check.
module pwsrc_phase #(
    parameter int TIME_WIDTH = pwsrc_pkg::TIME_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [TIME_WIDTH-1:0] time_ticks,
    input  logic [TIME_WIDTH-1:0] start_delay,
    input  logic                  period_nz,
    input  logic [TIME_WIDTH+1:0] period_eff,
    input  logic [TIME_WIDTH-1:0] cycle_limit,
    output logic                  out_valid,
    output logic [TIME_WIDTH-1:0] out_phase,
    output logic                  out_off
);

    localparam int DW = 2 * TIME_WIDTH + 2;

    logic [TIME_WIDTH:0]   vld_reg;
    logic [TIME_WIDTH:0]   act_reg;
    logic [TIME_WIDTH-1:0] rem_reg  [TIME_WIDTH+1];
    logic [TIME_WIDTH-1:0] quot_reg [TIME_WIDTH+1];
    logic [TIME_WIDTH-1:0] rem_c    [TIME_WIDTH];
    logic [TIME_WIDTH-1:0] take_c;
    logic                  out_valid_reg;
    logic [TIME_WIDTH-1:0] out_phase_reg;
    logic                  out_off_reg;
    logic [TIME_WIDTH:0]   cyc_c;
    logic                  ended_c;

    always_comb
    begin
        logic [DW-1:0] dvs;
        for (int k = 0; k < TIME_WIDTH; k++)
        begin
            dvs = DW'(period_eff) << (TIME_WIDTH - 1 - k);
            take_c[k] = DW'(rem_reg[k]) >= dvs;
            rem_c[k] = take_c[k] ? TIME_WIDTH'(DW'(rem_reg[k]) - dvs) : rem_reg[k];
        end
        cyc_c = {1'b0, quot_reg[TIME_WIDTH]} + (TIME_WIDTH+1)'(|rem_reg[TIME_WIDTH]);
        ended_c = (|cycle_limit) && (cyc_c > {1'b0, cycle_limit});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= {vld_reg[TIME_WIDTH-1:0], in_valid};
            out_valid_reg <= vld_reg[TIME_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= time_ticks - start_delay;
        quot_reg[0] <= '0;
        act_reg[0]  <= (time_ticks >= start_delay) && period_nz;
        for (int k = 0; k < TIME_WIDTH; k++)
        begin
            rem_reg[k+1]  <= rem_c[k];
            quot_reg[k+1] <= {quot_reg[k][TIME_WIDTH-2:0], take_c[k]};
            act_reg[k+1]  <= act_reg[k];
        end
        out_phase_reg <= rem_reg[TIME_WIDTH];
        out_off_reg   <= !act_reg[TIME_WIDTH] || ended_c;
    end

    assign out_valid = out_valid_reg;
    assign out_phase = out_phase_reg;
    assign out_off   = out_off_reg;

endmodule

// ===== sv/pwsrc_ramp.sv =====
// Level pipeline: segment select, ramp product, bit-per-stage scaling, final level.
module pwsrc_ramp #(
    parameter int TIME_WIDTH  = pwsrc_pkg::TIME_WIDTH_DEF,
    parameter int LEVEL_WIDTH = pwsrc_pkg::LEVEL_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [TIME_WIDTH-1:0]  in_phase,
    input  logic                   in_off,
    input  logic [TIME_WIDTH-1:0]  rise_time,
    input  logic [TIME_WIDTH-1:0]  fall_time,
    input  logic [TIME_WIDTH-1:0]  on_time,
    input  logic [LEVEL_WIDTH-1:0] off_level,
    input  logic [LEVEL_WIDTH-1:0] on_level,
    input  logic [LEVEL_WIDTH-1:0] diff_mag,
    input  logic                   diff_neg,
    output logic                   out_valid,
    output logic [LEVEL_WIDTH-1:0] level
);

    localparam int NW = TIME_WIDTH + LEVEL_WIDTH;

    logic                   a_vld_reg, b_vld_reg, c_vld_reg;
    logic                   a_off_reg, a_rise_reg;
    logic [TIME_WIDTH-1:0]  a_ph_reg, a_p1_reg;
    logic [1:0]             b_kind_reg;
    logic                   b_cand_reg;
    logic [TIME_WIDTH-1:0]  b_phase_reg;
    logic [1:0]             c_kind_reg;
    logic [TIME_WIDTH-1:0]  c_phase_reg;
    logic [TIME_WIDTH-1:0]  c_len_reg;
    logic [LEVEL_WIDTH:0]   dv_reg;
    logic [NW-1:0]          num_reg  [LEVEL_WIDTH+1];
    logic [LEVEL_WIDTH-1:0] q_reg    [LEVEL_WIDTH+1];
    logic [1:0]             kind_reg [LEVEL_WIDTH+1];
    logic [TIME_WIDTH-1:0]  len_reg  [LEVEL_WIDTH+1];
    logic [NW-1:0]          num_c    [LEVEL_WIDTH];
    logic [LEVEL_WIDTH-1:0] take_c;
    logic                   out_valid_reg;
    logic [LEVEL_WIDTH-1:0] level_reg;
    logic [LEVEL_WIDTH-1:0] level_next;

    always_comb
    begin
        logic [NW-1:0] dvs;
        for (int k = 0; k < LEVEL_WIDTH; k++)
        begin
            dvs = NW'(len_reg[k]) << (LEVEL_WIDTH - 1 - k);
            take_c[k] = num_reg[k] >= dvs;
            num_c[k] = take_c[k] ? num_reg[k] - dvs : num_reg[k];
        end
    end

    always_comb
    begin
        logic [LEVEL_WIDTH-1:0] q;
        q = q_reg[LEVEL_WIDTH];
        case (kind_reg[LEVEL_WIDTH])
            pwsrc_pkg::SEG_ON:   level_next = on_level;
            pwsrc_pkg::SEG_RISE: level_next = diff_neg ? off_level - q : off_level + q;
            pwsrc_pkg::SEG_FALL: level_next = diff_neg ? on_level + q : on_level - q;
            default:             level_next = off_level;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            dv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg     <= in_valid;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            dv_reg        <= {dv_reg[LEVEL_WIDTH-1:0], c_vld_reg};
            out_valid_reg <= dv_reg[LEVEL_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        a_off_reg  <= in_off;
        a_rise_reg <= in_phase < rise_time;
        a_ph_reg   <= in_phase;
        a_p1_reg   <= in_phase - rise_time;

        if (a_off_reg)
        begin
            b_kind_reg  <= pwsrc_pkg::SEG_OFF;
            b_cand_reg  <= 1'b0;
            b_phase_reg <= a_ph_reg;
        end
        else if (a_rise_reg)
        begin
            b_kind_reg  <= pwsrc_pkg::SEG_RISE;
            b_cand_reg  <= 1'b0;
            b_phase_reg <= a_ph_reg;
        end
        else if (a_p1_reg < on_time)
        begin
            b_kind_reg  <= pwsrc_pkg::SEG_ON;
            b_cand_reg  <= 1'b0;
            b_phase_reg <= a_ph_reg;
        end
        else
        begin
            b_kind_reg  <= pwsrc_pkg::SEG_OFF;
            b_cand_reg  <= 1'b1;
            b_phase_reg <= a_p1_reg - on_time;
        end

        c_phase_reg <= b_phase_reg;
        if (b_cand_reg && (b_phase_reg < fall_time))
        begin
            c_kind_reg <= pwsrc_pkg::SEG_FALL;
            c_len_reg  <= fall_time;
        end
        else
        begin
            c_kind_reg <= b_kind_reg;
            c_len_reg  <= rise_time;
        end

        num_reg[0]  <= NW'(c_phase_reg) * NW'(diff_mag);
        q_reg[0]    <= '0;
        kind_reg[0] <= c_kind_reg;
        len_reg[0]  <= c_len_reg;
        for (int k = 0; k < LEVEL_WIDTH; k++)
        begin
            num_reg[k+1]  <= num_c[k];
            q_reg[k+1]    <= {q_reg[k][LEVEL_WIDTH-2:0], take_c[k]};
            kind_reg[k+1] <= kind_reg[k];
            len_reg[k+1]  <= len_reg[k];
        end

        level_reg <= level_next;
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;

endmodule

// ===== sv/pulse_waveform_source_core.sv =====
// Top level of the trapezoidal pulse waveform source.
// One time value is taken in every clock cycle (busy stays low) and its level
// appears on level with done high for one cycle, after the phase and level
// pipelines; the result cannot be held off. The pipeline holds two division
// chains: TIME_WIDTH stages that reduce the elapsed time modulo the period,
// and LEVEL_WIDTH stages that scale the ramp. Configuration writes are always
// ready; a write also reaches time values that are already in the pipeline.
module pulse_waveform_source_core #(
    parameter int TIME_WIDTH  = pwsrc_pkg::TIME_WIDTH_DEF,
    parameter int LEVEL_WIDTH = pwsrc_pkg::LEVEL_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [TIME_WIDTH-1:0]                 time_ticks,
    output logic                                  done,
    output logic signed [LEVEL_WIDTH-1:0]         level,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pwsrc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [((TIME_WIDTH > LEVEL_WIDTH) ? TIME_WIDTH : LEVEL_WIDTH)-1:0] cfg_data
);

    logic [LEVEL_WIDTH-1:0] off_level, on_level, diff_mag;
    logic [TIME_WIDTH-1:0]  start_delay, rise_time, fall_time, on_time, cycle_limit;
    logic [TIME_WIDTH+1:0]  period_eff;
    logic                   period_nz, diff_neg;
    logic                   ph_valid, ph_off;
    logic [TIME_WIDTH-1:0]  ph_phase;
    logic [LEVEL_WIDTH-1:0] level_raw;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    pwsrc_cfg_regs #(
        .TIME_WIDTH (TIME_WIDTH),
        .LEVEL_WIDTH(LEVEL_WIDTH)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cfg_valid && cfg_ready),
        .wr_index   (cfg_index),
        .wr_data    (cfg_data),
        .off_level  (off_level),
        .on_level   (on_level),
        .start_delay(start_delay),
        .rise_time  (rise_time),
        .fall_time  (fall_time),
        .on_time    (on_time),
        .cycle_limit(cycle_limit),
        .period_nz  (period_nz),
        .period_eff (period_eff),
        .diff_mag   (diff_mag),
        .diff_neg   (diff_neg)
    );

    pwsrc_phase #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .time_ticks (time_ticks),
        .start_delay(start_delay),
        .period_nz  (period_nz),
        .period_eff (period_eff),
        .cycle_limit(cycle_limit),
        .out_valid  (ph_valid),
        .out_phase  (ph_phase),
        .out_off    (ph_off)
    );

    pwsrc_ramp #(
        .TIME_WIDTH (TIME_WIDTH),
        .LEVEL_WIDTH(LEVEL_WIDTH)
    ) u_ramp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (ph_valid),
        .in_phase (ph_phase),
        .in_off   (ph_off),
        .rise_time(rise_time),
        .fall_time(fall_time),
        .on_time  (on_time),
        .off_level(off_level),
        .on_level (on_level),
        .diff_mag (diff_mag),
        .diff_neg (diff_neg),
        .out_valid(done),
        .level    (level_raw)
    );

    assign level = level_raw;

endmodule

// ===== sv/pwsrc_checker.sv =====
// Port-level checks of the pulse waveform source and their binding to the top level.
module pwsrc_checker #(
    parameter int TIME_WIDTH  = pwsrc_pkg::TIME_WIDTH_DEF,
    parameter int LEVEL_WIDTH = pwsrc_pkg::LEVEL_WIDTH_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    localparam int LAT = pwsrc_pkg::pipe_latency(TIME_WIDTH, LEVEL_WIDTH);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted item produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching item");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !done)
        else $error("result during reset");

endmodule

bind pulse_waveform_source_core pwsrc_checker #(
    .TIME_WIDTH (TIME_WIDTH),
    .LEVEL_WIDTH(LEVEL_WIDTH)
) u_pwsrc_checker (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .done (done)
);

// ===== sim/tb_pulse_waveform_source_core.sv =====
// Testbench for the pulse waveform source: random and directed time samples checked by a scoreboard.
`timescale 1ns / 100ps

class level_scoreboard;
    logic [15:0] want_q[$];
    int errors;

    function void note(input logic [15:0] lv);
        want_q.insert(want_q.size(), lv);
    endfunction

    task report(input string msg);
        $display("%s", msg);
        errors++;
    endtask

    task check(input logic [15:0] got);
        logic [15:0] w;
        if (want_q.size() == 0)
        begin
            report($sformatf("unexpected level %0d", $signed(got)));
        end
        else
        begin
            w = want_q.pop_front();
            if (w !== got)
            begin
                report($sformatf("level mismatch: got %0d want %0d", $signed(got), $signed(w)));
            end
        end
    endtask
endclass

module tb_pulse_waveform_source_core;

    localparam int LAT = pwsrc_pkg::TIME_WIDTH_DEF + pwsrc_pkg::LEVEL_WIDTH_DEF + 6;
    localparam int IW  = pwsrc_pkg::CFG_INDEX_WIDTH;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] time_ticks;
    logic        done;
    logic signed [15:0] level;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [IW-1:0] cfg_index;
    logic [31:0] cfg_data;

    logic [15:0] r_off, r_on;
    logic [31:0] r_delay, r_rise, r_fall, r_ontime, r_period, r_cycles;
    level_scoreboard sb;
    int idle_cycles;
    int fails;

    pulse_waveform_source_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .time_ticks(time_ticks), .done(done), .level(level),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] scale_ramp(input logic [63:0] ph, input logic [63:0] mag,
                                                input logic [63:0] len);
        logic [127:0] p;
        p = ph * mag;
        return p / len;
    endfunction

    function automatic logic [15:0] predict_level(input logic [31:0] t);
        longint off, on, diff, lv, q;
        logic [63:0] per, el, ph, mag, cyc;
        off  = longint'($signed(r_off));
        on   = longint'($signed(r_on));
        diff = on - off;
        lv   = off;
        mag  = diff < 0 ? -diff : diff;
        per  = 64'(r_rise) + 64'(r_ontime) + 64'(r_fall);
        if (per < 64'(r_period))
            per = 64'(r_period);
        if (t >= r_delay && per != 0)
        begin
            el  = 64'(t - r_delay);
            cyc = el / per + ((el % per) != 0 ? 1 : 0);
            if (!(r_cycles != 0 && cyc > 64'(r_cycles)))
            begin
                ph = el % per;
                if (ph < r_rise)
                begin
                    q  = longint'(scale_ramp(ph, mag, r_rise));
                    lv = off + (diff < 0 ? -q : q);
                end
                else if (ph - r_rise < r_ontime)
                    lv = on;
                else if (ph - r_rise - r_ontime < r_fall)
                begin
                    q  = longint'(scale_ramp(ph - r_rise - r_ontime, mag, r_fall));
                    lv = on - (diff < 0 ? -q : q);
                end
            end
        end
        return lv[15:0];
    endfunction

    task automatic write_reg(input logic [IW-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pwsrc_pkg::REG_OFF_LEVEL:   r_off    = val[15:0];
            pwsrc_pkg::REG_ON_LEVEL:    r_on     = val[15:0];
            pwsrc_pkg::REG_START_DELAY: r_delay  = val;
            pwsrc_pkg::REG_RISE_TIME:   r_rise   = val;
            pwsrc_pkg::REG_FALL_TIME:   r_fall   = val;
            pwsrc_pkg::REG_ON_TIME:     r_ontime = val;
            pwsrc_pkg::REG_PERIOD_TIME: r_period = val;
            pwsrc_pkg::REG_CYCLE_LIMIT: r_cycles = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.want_q.size() != 0)
            @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    task automatic send_sample(input logic [31:0] t, input bit keep);
        start      <= 1'b1;
        time_ticks <= t;
        do @(posedge clk); while (busy);
        sb.note(predict_level(t));
        if (!keep)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_span(input int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(1, 8);
            2: return $urandom_range(0, 200);
            3: return $urandom;
            default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
    endfunction

    task automatic random_setting(input bit ext);
        write_reg(pwsrc_pkg::REG_OFF_LEVEL, $urandom);
        write_reg(pwsrc_pkg::REG_ON_LEVEL,
                  ext ? {16'h0, $urandom_range(0, 1) ? 16'h7FFF : 16'h8000} : $urandom);
        write_reg(pwsrc_pkg::REG_START_DELAY, rand_span($urandom_range(0, ext ? 4 : 2)));
        write_reg(pwsrc_pkg::REG_RISE_TIME, rand_span($urandom_range(0, ext ? 4 : 2)));
        write_reg(pwsrc_pkg::REG_FALL_TIME, rand_span($urandom_range(0, ext ? 4 : 2)));
        write_reg(pwsrc_pkg::REG_ON_TIME, rand_span($urandom_range(0, ext ? 4 : 2)));
        write_reg(pwsrc_pkg::REG_PERIOD_TIME, rand_span($urandom_range(0, ext ? 4 : 2)));
        write_reg(pwsrc_pkg::REG_CYCLE_LIMIT,
                  $urandom_range(0, 1) ? 0 : rand_span($urandom_range(1, 3)));
        write_reg(IW'(8 + $urandom_range(0, 7)), $urandom);
    endtask

    task automatic random_burst(input int n, input bit ext);
        logic [31:0] per, t;
        int len;
        per = r_rise + r_ontime + r_fall;
        if (per < r_period)
            per = r_period;
        while (n > 0)
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len && n > 0; i++, n--)
            begin
                if (ext || $urandom_range(0, 4) == 0)
                    t = $urandom;
                else
                    t = r_delay + $urandom_range(0, 4 * (per > 300 ? 300 : per) + 20);
                send_sample(t, i < len - 1 && n > 1);
            end
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(level);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("[pulse_waveform_source_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        idle_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        time_ticks = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        {r_off, r_on} = '0;
        {r_delay, r_rise, r_fall, r_ontime, r_period, r_cycles} = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_sample(32'd5, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        drain();
        write_reg(pwsrc_pkg::REG_OFF_LEVEL, 32'h8000);
        write_reg(pwsrc_pkg::REG_ON_LEVEL, 32'h7FFF);
        write_reg(pwsrc_pkg::REG_START_DELAY, 32'd10);
        write_reg(pwsrc_pkg::REG_RISE_TIME, 32'd4);
        write_reg(pwsrc_pkg::REG_FALL_TIME, 32'd3);
        write_reg(pwsrc_pkg::REG_ON_TIME, 32'd2);
        write_reg(pwsrc_pkg::REG_PERIOD_TIME, 32'd12);
        write_reg(pwsrc_pkg::REG_CYCLE_LIMIT, 32'd2);
        for (int t = 0; t < 20; t++)
            send_sample(32'(t * 2), t < 19);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'd0, 1'b0);
        drain();
        write_reg(pwsrc_pkg::REG_RISE_TIME, 32'hFFFF_FFFF);
        write_reg(pwsrc_pkg::REG_FALL_TIME, 32'hFFFF_FFFF);
        write_reg(pwsrc_pkg::REG_ON_TIME, 32'hFFFF_FFFF);
        write_reg(pwsrc_pkg::REG_CYCLE_LIMIT, 32'hFFFF_FFFF);
        write_reg(pwsrc_pkg::REG_START_DELAY, 32'd0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        drain();
        for (int ph = 0; ph < 30; ph++)
        begin
            random_setting(ph % 5 == 4);
            random_burst(55, ph % 5 == 4);
            drain();
        end
        fails = sb.errors + sb.want_q.size();
        if (fails == 0)
            $display("[pulse_waveform_source_core] OK");
        else
            $display("[pulse_waveform_source_core] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/pwsrc_pkg.sv
sv/pwsrc_cfg_regs.sv
sv/pwsrc_phase.sv
sv/pwsrc_ramp.sv
sv/pulse_waveform_source_core.sv
sv/pwsrc_checker.sv
sim/tb_pulse_waveform_source_core.sv
